// ===== rtl/sfc_pkg.sv =====
// Package for the scheduled colour fade controller.
// Holds field widths, fade constants, register index and mode codes.
// Depends on nothing; used by rtl/scheduled_colour_fade_controller.sv.
`default_nettype none

package sfc_pkg;

	localparam int unsigned FADE_STEPS = 50;

	localparam int unsigned MINUTE_W = 11;
	localparam int unsigned GAIN_W   = 17;
	localparam int unsigned STEP_W   = 10;
	localparam int unsigned MODE_W   = 2;
	localparam int unsigned ADDR_W   = 3;
	localparam int unsigned CHANNELS = 4;

	localparam logic [GAIN_W-1:0] Q16_ONE = GAIN_W'(65536);

	// Exact division by FADE_STEPS through a reciprocal: with l = ceil(log2 N)
	// and m = ceil(2^(W+l) / N), (x * m) >> (W+l) equals x / N for x < 2^W.
	localparam int unsigned PROD_W    = GAIN_W + STEP_W;
	localparam int unsigned STEP_BITS = $clog2(FADE_STEPS);
	localparam int unsigned DIV_SH    = PROD_W + STEP_BITS;
	localparam int unsigned RECIP_W   = PROD_W + 1;
	localparam int unsigned MUL_W     = PROD_W + RECIP_W;
	localparam logic [63:0] RECIP_FULL =
		((64'd1 << DIV_SH) + 64'(FADE_STEPS) - 64'd1) / 64'(FADE_STEPS);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

	localparam logic [STEP_W-1:0] STEPS_N   = STEP_W'(FADE_STEPS);
	localparam logic [PROD_W-1:0] CEIL_BIAS = PROD_W'(FADE_STEPS - 1);

	localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_TIMED = 2'd1;
	localparam logic [MODE_W-1:0] MODE_ON    = 2'd2;

	localparam logic [ADDR_W-1:0] REG_MODE         = 3'd0;
	localparam logic [ADDR_W-1:0] REG_START_MINUTE = 3'd1;
	localparam logic [ADDR_W-1:0] REG_END_MINUTE   = 3'd2;
	localparam logic [ADDR_W-1:0] REG_RED_LEVEL    = 3'd3;
	localparam logic [ADDR_W-1:0] REG_GREEN_LEVEL  = 3'd4;
	localparam logic [ADDR_W-1:0] REG_BLUE_LEVEL   = 3'd5;
	localparam logic [ADDR_W-1:0] REG_BRIGHT_LEVEL = 3'd6;

	localparam logic [MINUTE_W-1:0] START_RESET = MINUTE_W'(1200);
	localparam logic [MINUTE_W-1:0] END_RESET   = MINUTE_W'(420);
	localparam logic [GAIN_W-1:0]   RED_RESET    = GAIN_W'(65536);
	localparam logic [GAIN_W-1:0]   GREEN_RESET  = GAIN_W'(45875);
	localparam logic [GAIN_W-1:0]   BLUE_RESET   = GAIN_W'(32768);
	localparam logic [GAIN_W-1:0]   BRIGHT_RESET = GAIN_W'(65536);

	typedef struct packed {
		logic target_on;
		logic last;
	} fade_tag_t;

endpackage

`default_nettype wire

// ===== rtl/scheduled_colour_fade_controller.sv =====
// Top level of the scheduled colour fade controller: register file, schedule
// decision, fade sequencing and a three-stage gain pipeline.
// Depends on rtl/sfc_pkg.sv.
`default_nettype none

// The block accepts one word per clock cycle unless back-pressure has filled the
// gain pipeline. A schedule check (tuser 0) updates the target and never returns
// a word; a fade tick (tuser 1) during a running fade returns the four channel
// gains of the next step, with the target in tuser and tlast on the final step.
// The gain pipeline takes step decode into the first register, the per-channel
// step product into the second, and the reciprocal multiply that divides by the
// step count into the output register. Each stage holds while the one after it
// is full and stalled, so empty stages keep taking words under back-pressure.
// Configuration writes are expected only while no tick is in flight.
module scheduled_colour_fade_controller (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [2:0]  cfg_addr,
	input  wire logic [16:0] cfg_wdata,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // [10:0] minute_of_day, rest zero
	input  wire logic        s_axis_tuser,  // [0] kind
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [71:0]      m_axis_tdata,  // red, green, blue, bright gain, 17 bits each
	output logic             m_axis_tuser,  // [0] target_on
	output logic             m_axis_tlast
);

	localparam int unsigned GW = sfc_pkg::GAIN_W;
	localparam int unsigned PW = sfc_pkg::PROD_W;
	localparam int unsigned SW = sfc_pkg::STEP_W;
	localparam int unsigned NCH = sfc_pkg::CHANNELS;

	logic [sfc_pkg::MODE_W-1:0]   mode_q;
	logic [sfc_pkg::MINUTE_W-1:0] start_q;
	logic [sfc_pkg::MINUTE_W-1:0] end_q;
	logic [GW-1:0]                level_q [NCH];

	logic          filter_q;
	logic          active_q;
	logic [SW-1:0] step_q;

	logic                 v_s1;
	logic [SW-1:0]        k_s1;
	sfc_pkg::fade_tag_t   tag_s1;
	logic                 v_s2;
	logic [PW-1:0]        div_s2 [NCH];
	sfc_pkg::fade_tag_t   tag_s2;
	logic                 out_v_q;
	logic [GW-1:0]        gain_q [NCH];
	sfc_pkg::fade_tag_t   tag_q;

	logic rdy_s3, rdy_s2, rdy_s1;
	logic accept;
	logic kind;
	logic [sfc_pkg::MINUTE_W-1:0] minute;
	logic win_on;
	logic want;
	logic mode_valid;
	logic step_last;
	logic [SW-1:0] k_clamp;
	logic [GW-1:0] lvl [NCH];
	logic [GW-1:0] dlt [NCH];
	logic [PW-1:0] prod [NCH];
	logic [PW-1:0] div_next [NCH];
	logic [sfc_pkg::MUL_W-1:0] full [NCH];
	logic [GW-1:0] quo [NCH];
	logic [GW-1:0] gain_next [NCH];

	assign rdy_s3 = !out_v_q || m_axis_tready;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign s_axis_tready = rdy_s1;
	assign accept = s_axis_tvalid && rdy_s1;

	assign kind   = s_axis_tuser;
	assign minute = s_axis_tdata[sfc_pkg::MINUTE_W-1:0];

	always_comb begin
		if (end_q > start_q) begin
			win_on = (minute >= start_q) && (minute < end_q);
		end else if (end_q < start_q) begin
			win_on = (minute < end_q) || (minute >= start_q);
		end else begin
			win_on = 1'b0;
		end
	end

	always_comb begin
		want       = 1'b0;
		mode_valid = 1'b1;
		unique case (mode_q)
			sfc_pkg::MODE_OFF:   want = 1'b0;
			sfc_pkg::MODE_TIMED: want = win_on;
			sfc_pkg::MODE_ON:    want = 1'b1;
			default:             mode_valid = 1'b0;
		endcase
	end

	assign step_last = (step_q >= sfc_pkg::STEPS_N);

	always_comb begin
		if (step_q == '0) begin
			k_clamp = SW'(1);
		end else if (step_q > sfc_pkg::STEPS_N) begin
			k_clamp = sfc_pkg::STEPS_N;
		end else begin
			k_clamp = step_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= sfc_pkg::MODE_TIMED;
			start_q    <= sfc_pkg::START_RESET;
			end_q      <= sfc_pkg::END_RESET;
			level_q[0] <= sfc_pkg::RED_RESET;
			level_q[1] <= sfc_pkg::GREEN_RESET;
			level_q[2] <= sfc_pkg::BLUE_RESET;
			level_q[3] <= sfc_pkg::BRIGHT_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				sfc_pkg::REG_MODE:         mode_q     <= cfg_wdata[sfc_pkg::MODE_W-1:0];
				sfc_pkg::REG_START_MINUTE: start_q    <= cfg_wdata[sfc_pkg::MINUTE_W-1:0];
				sfc_pkg::REG_END_MINUTE:   end_q      <= cfg_wdata[sfc_pkg::MINUTE_W-1:0];
				sfc_pkg::REG_RED_LEVEL:    level_q[0] <= cfg_wdata;
				sfc_pkg::REG_GREEN_LEVEL:  level_q[1] <= cfg_wdata;
				sfc_pkg::REG_BLUE_LEVEL:   level_q[2] <= cfg_wdata;
				sfc_pkg::REG_BRIGHT_LEVEL: level_q[3] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_q <= 1'b0;
			active_q <= 1'b0;
			step_q   <= SW'(1);
		end else if (accept) begin
			if (!kind) begin
				if (mode_valid && !active_q && (filter_q != want)) begin
					step_q   <= SW'(1);
					active_q <= 1'b1;
					filter_q <= want;
				end
			end else if (active_q) begin
				if (step_last) begin
					active_q <= 1'b0;
				end
				step_q <= step_q + SW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= accept && kind && active_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			k_s1             <= k_clamp;
			tag_s1.target_on <= filter_q;
			tag_s1.last      <= step_last;
		end
	end

	for (genvar c = 0; c < NCH; c++) begin : g_chan
		assign lvl[c]  = (level_q[c] > sfc_pkg::Q16_ONE) ? sfc_pkg::Q16_ONE : level_q[c];
		assign dlt[c]  = sfc_pkg::Q16_ONE - lvl[c];
		assign prod[c] = PW'(dlt[c]) * PW'(k_s1);
		assign div_next[c] = tag_s1.target_on ? (prod[c] + sfc_pkg::CEIL_BIAS) : prod[c];
		assign full[c] = sfc_pkg::MUL_W'(div_s2[c]) * sfc_pkg::MUL_W'(sfc_pkg::RECIP);
		assign quo[c]  = full[c][sfc_pkg::DIV_SH +: GW];
		assign gain_next[c] = tag_s2.target_on ? (sfc_pkg::Q16_ONE - quo[c]) : (lvl[c] + quo[c]);

		always_ff @(posedge clk) begin
			if (rdy_s2) begin
				div_s2[c] <= div_next[c];
			end
			if (rdy_s3) begin
				gain_q[c] <= gain_next[c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				out_v_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			tag_s2 <= tag_s1;
		end
		if (rdy_s3) begin
			tag_q <= tag_s2;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {4'd0, gain_q[3], gain_q[2], gain_q[1], gain_q[0]};
	assign m_axis_tuser  = tag_q.target_on;
	assign m_axis_tlast  = tag_q.last;

`ifndef NO_ASSERTIONS
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (step_q >= SW'(1)) && (step_q <= sfc_pkg::STEPS_N))
		else $error("Step index left its range during a fade.");

	a_last_ends_fade: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind && active_q && step_last) |=> !active_q)
		else $error("Fade still running after its final step.");

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (gain_q[0] <= sfc_pkg::Q16_ONE) && (gain_q[1] <= sfc_pkg::Q16_ONE)
			&& (gain_q[2] <= sfc_pkg::Q16_ONE) && (gain_q[3] <= sfc_pkg::Q16_ONE))
		else $error("Output gain above unity.");

	a_no_idle_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !kind) |=> !v_s1)
		else $error("Schedule check produced a word.");
`endif

endmodule

`default_nettype wire
